// File: hw/rtl/lsgf_pkg.sv
// ----------------------------------------------------------------------------
// lsgf_pkg: shared types and constants of the LCD subpixel gamma filter
// Holds the item codes, the filter weights, the term helper and the structs
// that pass between the lanes, the merge stage and the output queue.
// ----------------------------------------------------------------------------
package lsgf_pkg;

	// Item kinds carried in tuser on the input stream.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// One lane for each subpixel of a triplet.
	localparam int LANES = 3;

	// Gamma table geometry.
	localparam int GAMMA_DEPTH = 256;
	localparam int GAMMA_AW    = 8;

	// Filter weights on a scale of 255.
	localparam logic [6:0] K_EDGE   = 7'd28;
	localparam logic [6:0] K_NEAR   = 7'd56;
	localparam logic [6:0] K_CENTER = 7'd85;

	// One RGB triplet, first subpixel in the low byte.
	typedef struct packed {
		logic [7:0] third;
		logic [7:0] middle;
		logic [7:0] first;
	} pixel_t;

	// The three weighted forms of one gamma-mapped subpixel.
	typedef struct packed {
		logic [6:0] w85;
		logic [5:0] w56;
		logic [4:0] w28;
	} term_set_t;

	// Terms of one lane for the held-triplet result (a) and the row-end result (b).
	typedef struct packed {
		term_set_t a;
		term_set_t b;
	} lane_terms_t;

	// Raw neighbor subpixels of both possible results of one item.
	typedef struct packed {
		logic [7:0] a_l1;
		logic [7:0] a_l2;
		logic [7:0] a_r0;
		logic [7:0] a_r1;
		logic [7:0] b_l1;
		logic [7:0] b_l2;
	} nbr_t;

	// One queued item: up to two results.
	typedef struct packed {
		logic   has_a;
		logic   has_b;
		pixel_t res_a;
		pixel_t res_b;
	} queue_entry_t;

	// floor(x * k / 255) for 8-bit x and a 7-bit weight, by the reciprocal
	// identity floor(p / 255) = (p + (p >> 8) + 1) >> 8, valid for p below 65535.
	function automatic logic [7:0] wterm(input logic [7:0] x, input logic [6:0] k);
		logic [15:0] prod;
		logic [15:0] acc;
		prod = 16'(x) * 16'(k);
		acc  = prod + (prod >> 8) + 16'd1;
		return acc[15:8];
	endfunction

	// All three weighted terms of one subpixel value.
	function automatic term_set_t make_terms(input logic [7:0] g);
		term_set_t  t;
		logic [7:0] v85;
		logic [7:0] v56;
		logic [7:0] v28;
		v85   = wterm(g, K_CENTER);
		v56   = wterm(g, K_NEAR);
		v28   = wterm(g, K_EDGE);
		t.w85 = v85[6:0];
		t.w56 = v56[5:0];
		t.w28 = v28[4:0];
		return t;
	endfunction

endpackage

// File: hw/rtl/lcd_subpixel_gamma_filter.sv
// ----------------------------------------------------------------------------
// lcd_subpixel_gamma_filter: five-tap LCD subpixel filter with gamma table
// Gamma-maps each centre triplet, filters it with its raw neighbors and
// emits the triplets of a row one behind the input.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Carries
// s_axis    in         s_axis_tvalid/s_axis_tready  gamma load or pixel triplet
// m_axis    out        m_axis_tvalid/m_axis_tready  filtered triplet
//
// One item is taken per cycle while the input is not stalled; three gamma lanes
// with their own table copies and a merge adder run in a three-stage pipeline,
// and each result passes the lookup and weighting registers and the output queue
// before it can leave. A row-end item with a held triplet makes two results and
// takes two output transfers. Reset clears the row state, the pipeline and
// the output queue; the gamma table is not cleared. Input is stalled only
// while FIFO_DEPTH items with results are in flight or queued; a depth of
// four or more keeps one item per cycle while the output takes one per cycle.
//
module lcd_subpixel_gamma_filter #(
	parameter int FIFO_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // gamma_index, gamma_value, sample_first,
	                                   // sample_middle, sample_last
	input  logic        s_axis_tlast,  // row_end
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // filtered_first, filtered_middle, filtered_third
	output logic        m_axis_tlast,  // row_done
	output logic        m_axis_tuser   // run_last
);
	import lsgf_pkg::*;

	localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

	logic [7:0]  gamma_index;
	logic [7:0]  gamma_value;
	pixel_t      cur;
	logic        accept;
	logic        load_acc;
	logic        pix_acc;
	logic        need_slot;
	logic        pop;

	pixel_t      held_q;
	logic        held_valid_q;
	logic [7:0]  left_mid_q;
	logic [7:0]  left_last_q;
	logic [PEND_W-1:0] pend_q;

	nbr_t        nbr_s1;
	logic        valid_a_s1;
	logic        valid_b_s1;
	logic        valid_a_s2;
	logic        valid_b_s2;

	logic [7:0]  held_bytes [LANES];
	logic [7:0]  cur_bytes [LANES];
	lane_terms_t terms_s2 [LANES];
	pixel_t      res_a;
	pixel_t      res_b;
	queue_entry_t push_entry;

	// Input fields and transfer qualifiers.
	always_comb begin
		gamma_index   = s_axis_tdata[7:0];
		gamma_value   = s_axis_tdata[15:8];
		cur.first     = s_axis_tdata[23:16];
		cur.middle    = s_axis_tdata[31:24];
		cur.third     = s_axis_tdata[39:32];
		s_axis_tready = (pend_q < PEND_W'(FIFO_DEPTH));
		accept        = s_axis_tvalid && s_axis_tready;
		load_acc      = accept && (s_axis_tuser == OP_LOAD);
		pix_acc       = accept && (s_axis_tuser == OP_PIXEL);
		need_slot     = pix_acc && (held_valid_q || s_axis_tlast);
		held_bytes[0] = held_q.first;
		held_bytes[1] = held_q.middle;
		held_bytes[2] = held_q.third;
		cur_bytes[0]  = cur.first;
		cur_bytes[1]  = cur.middle;
		cur_bytes[2]  = cur.third;
	end

	// Row state: the held triplet and the left neighbor pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
			left_mid_q   <= '0;
			left_last_q  <= '0;
		end else if (pix_acc) begin
			if (s_axis_tlast) begin
				held_q       <= '0;
				held_valid_q <= 1'b0;
				left_mid_q   <= '0;
				left_last_q  <= '0;
			end else begin
				if (held_valid_q) begin
					left_mid_q  <= held_q.middle;
					left_last_q <= held_q.third;
				end
				held_q       <= cur;
				held_valid_q <= 1'b1;
			end
		end
	end

	// Items accepted whose results have not all left the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (need_slot && !pop) begin
			pend_q <= pend_q + 1'b1;
		end else if (pop && !need_slot) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// Neighbor subpixels of both results, taken with the table lookup.
	always_ff @(posedge clk) begin
		nbr_s1.a_l1 <= left_mid_q;
		nbr_s1.a_l2 <= left_last_q;
		nbr_s1.a_r0 <= cur.first;
		nbr_s1.a_r1 <= cur.middle;
		nbr_s1.b_l1 <= held_valid_q ? held_q.middle : left_mid_q;
		nbr_s1.b_l2 <= held_valid_q ? held_q.third : left_last_q;
	end

	// Result valid flags along the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_a_s1 <= 1'b0;
			valid_b_s1 <= 1'b0;
			valid_a_s2 <= 1'b0;
			valid_b_s2 <= 1'b0;
		end else begin
			valid_a_s1 <= pix_acc && held_valid_q;
			valid_b_s1 <= pix_acc && s_axis_tlast;
			valid_a_s2 <= valid_a_s1;
			valid_b_s2 <= valid_b_s1;
		end
	end

	// One lane per subpixel position.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		lsgf_lane u_lane (
			.clk       (clk),
			.wr_en     (load_acc),
			.wr_addr   (gamma_index),
			.wr_data   (gamma_value),
			.rd_en     (pix_acc),
			.rd_addr_a (held_bytes[i]),
			.rd_addr_b (cur_bytes[i]),
			.terms_s2  (terms_s2[i])
		);
	end

	lsgf_merge u_merge (
		.clk      (clk),
		.nbr_s1   (nbr_s1),
		.terms_s2 (terms_s2),
		.res_a    (res_a),
		.res_b    (res_b)
	);

	// Queue entry of one item.
	always_comb begin
		push_entry.has_a = valid_a_s2;
		push_entry.has_b = valid_b_s2;
		push_entry.res_a = res_a;
		push_entry.res_b = res_b;
	end

	lsgf_outq #(
		.DEPTH (FIFO_DEPTH)
	) u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (valid_a_s2 || valid_b_s2),
		.push_entry    (push_entry),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// File: hw/rtl/lsgf_lane.sv
// ----------------------------------------------------------------------------
// lsgf_lane: gamma lookup and weighting for one subpixel position
// Keeps its own copy of the gamma table, looks up the held and the new
// subpixel into registered read ports and forms their weighted terms in the next.
// ----------------------------------------------------------------------------
module lsgf_lane (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [lsgf_pkg::GAMMA_AW-1:0] wr_addr,
	input  logic [7:0]                  wr_data,
	input  logic                        rd_en,
	input  logic [lsgf_pkg::GAMMA_AW-1:0] rd_addr_a,
	input  logic [lsgf_pkg::GAMMA_AW-1:0] rd_addr_b,
	output lsgf_pkg::lane_terms_t       terms_s2
);
	import lsgf_pkg::*;

	logic [7:0] gamma_mem [GAMMA_DEPTH];
	logic [7:0] g_a_s1;
	logic [7:0] g_b_s1;

	// Gamma table copy: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			gamma_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			g_a_s1 <= gamma_mem[rd_addr_a];
			g_b_s1 <= gamma_mem[rd_addr_b];
		end
	end

	// Weighted terms of both looked-up values.
	always_ff @(posedge clk) begin
		terms_s2.a <= make_terms(g_a_s1);
		terms_s2.b <= make_terms(g_b_s1);
	end

endmodule

// File: hw/rtl/lsgf_merge.sv
// ----------------------------------------------------------------------------
// lsgf_merge: combines lane terms with neighbor terms into filtered triplets
// Weights the raw neighbor subpixels alongside the lanes and adds up to five
// terms of each output subpixel for both results of an item.
// ----------------------------------------------------------------------------
module lsgf_merge (
	input  logic                  clk,
	input  lsgf_pkg::nbr_t        nbr_s1,
	input  lsgf_pkg::lane_terms_t terms_s2 [lsgf_pkg::LANES],
	output lsgf_pkg::pixel_t      res_a,
	output lsgf_pkg::pixel_t      res_b
);
	import lsgf_pkg::*;

	term_set_t a_l1_s2;
	term_set_t a_l2_s2;
	term_set_t a_r0_s2;
	term_set_t a_r1_s2;
	term_set_t b_l1_s2;
	term_set_t b_l2_s2;
	logic [8:0] sum_a0;
	logic [8:0] sum_a1;
	logic [8:0] sum_a2;
	logic [8:0] sum_b0;
	logic [8:0] sum_b1;
	logic [8:0] sum_b2;

	// Neighbor terms, aligned with the lane terms.
	always_ff @(posedge clk) begin
		a_l1_s2 <= make_terms(nbr_s1.a_l1);
		a_l2_s2 <= make_terms(nbr_s1.a_l2);
		a_r0_s2 <= make_terms(nbr_s1.a_r0);
		a_r1_s2 <= make_terms(nbr_s1.a_r1);
		b_l1_s2 <= make_terms(nbr_s1.b_l1);
		b_l2_s2 <= make_terms(nbr_s1.b_l2);
	end

	// Five-tap sums; the row-end result has no right neighbor.
	always_comb begin
		sum_a0 = 9'(a_l1_s2.w28) + 9'(a_l2_s2.w56) + 9'(terms_s2[0].a.w85)
			+ 9'(terms_s2[1].a.w56) + 9'(terms_s2[2].a.w28);
		sum_a1 = 9'(a_l2_s2.w28) + 9'(terms_s2[0].a.w56) + 9'(terms_s2[1].a.w85)
			+ 9'(terms_s2[2].a.w56) + 9'(a_r0_s2.w28);
		sum_a2 = 9'(terms_s2[0].a.w28) + 9'(terms_s2[1].a.w56) + 9'(terms_s2[2].a.w85)
			+ 9'(a_r0_s2.w56) + 9'(a_r1_s2.w28);
		sum_b0 = 9'(b_l1_s2.w28) + 9'(b_l2_s2.w56) + 9'(terms_s2[0].b.w85)
			+ 9'(terms_s2[1].b.w56) + 9'(terms_s2[2].b.w28);
		sum_b1 = 9'(b_l2_s2.w28) + 9'(terms_s2[0].b.w56) + 9'(terms_s2[1].b.w85)
			+ 9'(terms_s2[2].b.w56);
		sum_b2 = 9'(terms_s2[0].b.w28) + 9'(terms_s2[1].b.w56) + 9'(terms_s2[2].b.w85);
		res_a.first  = sum_a0[7:0];
		res_a.middle = sum_a1[7:0];
		res_a.third  = sum_a2[7:0];
		res_b.first  = sum_b0[7:0];
		res_b.middle = sum_b1[7:0];
		res_b.third  = sum_b2[7:0];
	end

endmodule

// File: hw/rtl/lsgf_outq.sv
// ----------------------------------------------------------------------------
// lsgf_outq: output queue of result pairs
// Stores one entry per item that has results and hands the results out one
// transfer at a time, first the held-triplet result, then the row-end one.
// ----------------------------------------------------------------------------
module lsgf_outq #(
	parameter int DEPTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lsgf_pkg::queue_entry_t push_entry,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [23:0]            m_axis_tdata,  // filtered_first, filtered_middle, filtered_third
	output logic                   m_axis_tlast,  // row_done
	output logic                   m_axis_tuser   // run_last
);
	import lsgf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	queue_entry_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sub_q;
	queue_entry_t     head;
	logic             send_b;
	logic             xfer;

	// Head entry and the result it shows next.
	always_comb begin
		head          = entry_q[rd_ptr_q];
		send_b        = !head.has_a || sub_q;
		m_axis_tvalid = (cnt_q != '0);
		m_axis_tdata  = send_b ? head.res_b : head.res_a;
		m_axis_tlast  = send_b;
		m_axis_tuser  = send_b || !head.has_b;
		xfer          = m_axis_tvalid && m_axis_tready;
		pop           = xfer && (send_b || !head.has_b);
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers, fill count and the second-result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (xfer) begin
				sub_q <= !pop;
			end
		end
	end

endmodule

// File: hw/rtl/lsgf_checker.sv
// ----------------------------------------------------------------------------
// lsgf_checker: port-level checks of the LCD subpixel gamma filter
// Watches the output stream for the ordering of paired results and for a
// stalled result that changes, and the input ready for unknown values.
// ----------------------------------------------------------------------------
module lsgf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// A stalled result keeps its data and flags.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
		&& $stable(m_axis_tlast))
		else $error("output result changed while stalled");

	// A result that ends its row is always the last of its item.
	a_row_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("row end result not marked as last of its item");

	// The first of a pair is followed at once by the row-end result.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tuser |=>
		m_axis_tvalid && m_axis_tlast && m_axis_tuser)
		else $error("second result of a pair missing");

	// The input ready always has a known value out of reset.
	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(s_axis_tready))
		else $error("input ready is unknown");

endmodule

bind lcd_subpixel_gamma_filter lsgf_checker u_lsgf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
